### hdl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// Route repeater cache package
// Shared widths, command codes and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rrc_pkg;

  localparam int unsigned NODE_W            = 12;
  localparam int unsigned REP_W             = 8;
  localparam int unsigned CMD_W             = 2;
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic load;
    logic rd;
    logic commit;
  } rrc_ctl_t;

  typedef struct packed {
    logic needs_scan;
    logic last_addr;
  } rrc_sts_t;

endpackage

### hdl/route_repeater_cache.sv
// ----------------------------------------------------------------------------
// Route repeater cache
// Associative table of node id and repeater count entries with set, get and
// clear commands, one result word per command word.
// ----------------------------------------------------------------------------
//   Channel  | Direction | tdata                          | tuser
//   s_axis   | in        | node_id[11:0] repeaters_in[19:12] | command[1:0]
//   m_axis   | out       | repeaters_out[7:0]             | found[0] dropped[1]
//
// Set and get words scan every entry through one RAM read port, one entry
// per cycle, and a new word is taken only after the command has committed.
// Clear and the unused command skip the scan and go straight to commit.
// Reset empties the table at once through per-entry valid bits.
// A new word is accepted while a result still waits; the commit waits for the
// output register to be free.
module route_repeater_cache #(
  parameter int unsigned TABLE_ENTRIES = rrc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // node_id[11:0], repeaters_in[19:12], zero pad
  input  logic [1:0]  s_axis_tuser_i,  // command[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // repeaters_out[7:0]
  output logic [1:0]  m_axis_tuser_o   // found[0], dropped[1]
);

  rrc_pkg::rrc_ctl_t ctl;
  rrc_pkg::rrc_sts_t sts;
  logic              found;
  logic              dropped;

  rrc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  rrc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .cmd_i     (s_axis_tuser_i),
    .node_i    (s_axis_tdata_i[11:0]),
    .reps_i    (s_axis_tdata_i[19:12]),
    .reps_o    (m_axis_tdata_o),
    .found_o   (found),
    .dropped_o (dropped)
  );

  assign m_axis_tuser_o = {dropped, found};

endmodule

### hdl/rrc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rrc_ctrl.sv
// ----------------------------------------------------------------------------
// Route repeater cache controller
// Sequences load, table scan and commit, and owns the output word valid flag.
// ----------------------------------------------------------------------------
module rrc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  rrc_pkg::rrc_sts_t sts_i,
  output rrc_pkg::rrc_ctl_t ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   out_free;

  assign out_free   = !m_valid_q || m_ready_i;
  assign s_ready_o  = (state_q == ST_IDLE);
  assign m_valid_o  = m_valid_q;

  always_comb begin
    ctl_o        = '0;
    ctl_o.load   = (state_q == ST_IDLE) && s_valid_i;
    ctl_o.rd     = (state_q == ST_SCAN);
    ctl_o.commit = (state_q == ST_COMMIT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (ctl_o.commit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_valid_i) begin
            state_q <= sts_i.needs_scan ? ST_SCAN : ST_COMMIT;
          end
        end
        ST_SCAN: begin
          if (sts_i.last_addr) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/rrc_dp.sv
// ----------------------------------------------------------------------------
// Route repeater cache datapath
// Holds the table RAM and valid bits, scans for the first match and the first
// free slot, and applies the update and result on commit.
// ----------------------------------------------------------------------------
module rrc_dp #(
  parameter int unsigned TABLE_ENTRIES = rrc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrc_pkg::rrc_ctl_t          ctl_i,
  output rrc_pkg::rrc_sts_t          sts_o,
  input  logic [rrc_pkg::CMD_W-1:0]  cmd_i,
  input  logic [rrc_pkg::NODE_W-1:0] node_i,
  input  logic [rrc_pkg::REP_W-1:0]  reps_i,
  output logic [rrc_pkg::REP_W-1:0]  reps_o,
  output logic                       found_o,
  output logic                       dropped_o
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned EW = rrc_pkg::NODE_W + rrc_pkg::REP_W;

  logic [rrc_pkg::CMD_W-1:0]  cmd_q;
  logic [rrc_pkg::NODE_W-1:0] node_q;
  logic [rrc_pkg::REP_W-1:0]  reps_q;
  logic [IW-1:0]              addr_q;
  logic [IW-1:0]              idx_q;
  logic                       cmp_v_q;
  logic                       hit_q;
  logic [IW-1:0]              hit_idx_q;
  logic [rrc_pkg::REP_W-1:0]  hit_reps_q;
  logic                       free_q;
  logic [IW-1:0]              free_idx_q;
  logic [TABLE_ENTRIES-1:0]   valid_q;
  logic [rrc_pkg::REP_W-1:0]  reps_out_q;
  logic                       found_q;
  logic                       dropped_q;

  logic [EW-1:0]              rdata;
  logic [rrc_pkg::NODE_W-1:0] ent_node;
  logic [rrc_pkg::REP_W-1:0]  ent_reps;
  logic                       is_set;
  logic                       is_get;
  logic                       we;
  logic [IW-1:0]              waddr;
  logic [EW-1:0]              wdata;

  assign sts_o.needs_scan = (cmd_i == rrc_pkg::CMD_SET) || (cmd_i == rrc_pkg::CMD_GET);
  assign sts_o.last_addr  = (addr_q == IW'(TABLE_ENTRIES - 1));

  assign ent_node = valid_q[idx_q] ? rdata[EW-1:rrc_pkg::REP_W] : '0;
  assign ent_reps = valid_q[idx_q] ? rdata[rrc_pkg::REP_W-1:0] : '0;

  assign is_set = (cmd_q == rrc_pkg::CMD_SET);
  assign is_get = (cmd_q == rrc_pkg::CMD_GET);

  always_comb begin
    we    = 1'b0;
    waddr = hit_idx_q;
    wdata = {(reps_q == '0) ? {rrc_pkg::NODE_W{1'b0}} : node_q, reps_q};
    if (ctl_i.commit && is_set) begin
      if (hit_q) begin
        we = 1'b1;
      end else if ((reps_q != '0) && free_q) begin
        we    = 1'b1;
        waddr = free_idx_q;
        wdata = {node_q, reps_q};
      end
    end
  end

  rrc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (ctl_i.rd),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      cmp_v_q <= 1'b0;
    end else begin
      cmp_v_q <= ctl_i.rd;
      if (ctl_i.commit && (cmd_q == rrc_pkg::CMD_CLEAR)) begin
        valid_q <= '0;
      end else if (we) begin
        valid_q[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      node_q <= node_i;
      reps_q <= reps_i;
      addr_q <= '0;
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (ctl_i.rd) begin
        idx_q  <= addr_q;
        addr_q <= addr_q + 1'b1;
      end
      if (cmp_v_q && !hit_q && (ent_node == node_q)) begin
        hit_q      <= 1'b1;
        hit_idx_q  <= idx_q;
        hit_reps_q <= ent_reps;
      end
      if (cmp_v_q && !free_q && (ent_node == '0)) begin
        free_q     <= 1'b1;
        free_idx_q <= idx_q;
      end
    end
    if (ctl_i.commit) begin
      reps_out_q <= (is_get && hit_q) ? hit_reps_q : '0;
      found_q    <= (is_set || is_get) && hit_q;
      dropped_q  <= is_set && !hit_q && (reps_q != '0) && !free_q;
    end
  end

  assign reps_o    = reps_out_q;
  assign found_o   = found_q;
  assign dropped_o = dropped_q;

endmodule

### hdl/rrc_checker.sv
// ----------------------------------------------------------------------------
// Route repeater cache checker
// Port-level assertions on the cache, bound to the top level.
// ----------------------------------------------------------------------------
module rrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [7:0]  m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // A result word is held until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word dropped while stalled");

  // The block is busy in the cycle after taking a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("word accepted while a command is in flight");

  // A dropped set never reports a matching entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("found and dropped both set");

  // A nonzero count only comes back with a hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o != 8'd0) |-> m_axis_tuser_o[0])
    else $error("count returned without a hit");

endmodule

bind route_repeater_cache rrc_checker u_rrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
